// File: rtl/b58m_pkg.sv
// Shared types, codes and the Base58 symbol decoder for the multi-pattern matcher.
package b58m_pkg;

   localparam int EPOCH_W = 8;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_TRANS = 2'd1,
      KIND_RANGE = 2'd2,
      KIND_ID    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TW_MUL,
      ST_TW_WR,
      ST_TRANS,
      ST_NODE,
      ST_RANGE,
      ST_LIST,
      ST_ID,
      ST_SEEN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_wr;
      logic tw_mul;
      logic tw_wr;
      logic trans_rd;
      logic node_upd;
      logic list_init;
      logic id_rd;
      logic seen_rd;
      logic j_inc;
      logic match;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic in_first;
      logic in_sym_ok;
      logic epoch_wrap;
      logic clr_done;
      logic list_done;
      logic pos_oob;
      logic id_ok;
      logic seen_hit;
      logic pend_v;
      logic out_free;
   } status_type;

   // Alphabet position of a byte; bit 6 set marks a byte outside Base58.
   function automatic logic [6:0] sym_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      if (c >= 8'd49 && c <= 8'd57)       r = 7'(c - 8'd49);
      else if (c >= 8'd65 && c <= 8'd72)  r = 7'(c - 8'd56);
      else if (c >= 8'd74 && c <= 8'd78)  r = 7'(c - 8'd57);
      else if (c >= 8'd80 && c <= 8'd90)  r = 7'(c - 8'd58);
      else if (c >= 8'd97 && c <= 8'd107) r = 7'(c - 8'd64);
      else if (c >= 8'd109 && c <= 8'd122) r = 7'(c - 8'd65);
      return r;
   endfunction

endpackage

// File: rtl/b58m_ctrl.sv
// Sequencing state machine of the multi-pattern matcher.
module b58m_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   output logic                 req_ready,
   input  b58m_pkg::status_type status,
   output b58m_pkg::cmd_type    cmd
);

   b58m_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b58m_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         b58m_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = b58m_pkg::ST_IDLE;
            end
         end
         b58m_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (b58m_pkg::kind_type'(req_kind))
                  b58m_pkg::KIND_CHAR: begin
                     if (status.in_first) begin
                        if (status.epoch_wrap) begin
                           state_in = b58m_pkg::ST_CLEAR;
                        end
                     end else if (status.in_sym_ok) begin
                        state_in = b58m_pkg::ST_TRANS;
                     end
                  end
                  b58m_pkg::KIND_TRANS: state_in = b58m_pkg::ST_TW_MUL;
                  default: state_in = b58m_pkg::ST_IDLE;
               endcase
            end
         end
         b58m_pkg::ST_TW_MUL: begin
            cmd.tw_mul = 1'b1;
            state_in   = b58m_pkg::ST_TW_WR;
         end
         b58m_pkg::ST_TW_WR: begin
            cmd.tw_wr = 1'b1;
            state_in  = b58m_pkg::ST_IDLE;
         end
         b58m_pkg::ST_TRANS: begin
            cmd.trans_rd = 1'b1;
            state_in     = b58m_pkg::ST_NODE;
         end
         b58m_pkg::ST_NODE: begin
            cmd.node_upd = 1'b1;
            state_in     = b58m_pkg::ST_RANGE;
         end
         b58m_pkg::ST_RANGE: begin
            cmd.list_init = 1'b1;
            state_in      = b58m_pkg::ST_LIST;
         end
         b58m_pkg::ST_LIST: begin
            if (status.list_done) begin
               state_in = b58m_pkg::ST_FLUSH;
            end else if (status.pos_oob) begin
               cmd.j_inc = 1'b1;
            end else begin
               cmd.id_rd = 1'b1;
               state_in  = b58m_pkg::ST_ID;
            end
         end
         b58m_pkg::ST_ID: begin
            if (status.id_ok) begin
               cmd.seen_rd = 1'b1;
               state_in    = b58m_pkg::ST_SEEN;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = b58m_pkg::ST_LIST;
            end
         end
         b58m_pkg::ST_SEEN: begin
            if (status.seen_hit) begin
               cmd.j_inc = 1'b1;
               state_in  = b58m_pkg::ST_LIST;
            end else if (!status.pend_v || status.out_free) begin
               cmd.match = 1'b1;
               state_in  = b58m_pkg::ST_LIST;
            end
         end
         b58m_pkg::ST_FLUSH: begin
            if (!status.pend_v) begin
               state_in = b58m_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = b58m_pkg::ST_IDLE;
            end
         end
         default: state_in = b58m_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: rtl/b58m_dp.sv
// Datapath of the multi-pattern matcher: tables, seen store, list walk and result register.
module b58m_dp #(
   parameter int ALPHABET_SIZE    = 58,
   parameter int MAX_NODES        = 4096,
   parameter int MAX_WORDS        = 1024,
   parameter int ID_LIST_DEPTH    = 8192,
   parameter int MAX_OUT_PER_NODE = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  b58m_pkg::cmd_type    cmd,
   output b58m_pkg::status_type status,
   input  logic [10:0]          num_words,
   input  logic [1:0]           req_kind,
   input  logic                 req_first_char,
   input  logic [7:0]           req_character,
   input  logic [11:0]          req_table_state,
   input  logic [5:0]           req_symbol,
   input  logic [11:0]          req_next_state,
   input  logic [12:0]          req_out_start,
   input  logic [4:0]           req_out_len,
   input  logic [12:0]          req_out_index,
   input  logic [9:0]           req_word_id,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_match_id,
   output logic                 rsp_last
);

   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int TDEPTH  = MAX_NODES * ALPHABET_SIZE;
   localparam int TADDR_W = $clog2(TDEPTH);
   localparam int WORD_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int IDX_W   = (ID_LIST_DEPTH > 1) ? $clog2(ID_LIST_DEPTH) : 1;
   localparam int LEN_W   = $clog2(MAX_OUT_PER_NODE + 1);
   localparam int POS_W   = 14;
   localparam int SHIFT   = 29;
   localparam longint RECIP = (64'd1 << SHIFT) / MAX_NODES;

   logic [11:0]           trans_mem [TDEPTH];
   logic [12:0]           rstart_mem [MAX_NODES];
   logic [4:0]            rlen_mem [MAX_NODES];
   logic [9:0]            id_mem [ID_LIST_DEPTH];
   logic [b58m_pkg::EPOCH_W-1:0] seen_mem [MAX_WORDS];

   logic [NODE_W-1:0]     node_ff;
   logic [5:0]            sym_ff;
   logic [11:0]           trans_q_ff;
   logic [12:0]           rstart_q_ff;
   logic [4:0]            rlen_q_ff;
   logic [12:0]           start_ff;
   logic [LEN_W-1:0]      len_ff, j_ff;
   logic [9:0]            id_q_ff;
   logic [b58m_pkg::EPOCH_W-1:0] seen_q_ff, epoch_ff;
   logic [WORD_W:0]       clr_ff;
   logic                  pend_v_ff;
   logic [9:0]            pend_id_ff;
   logic                  out_v_ff, out_last_ff;
   logic [9:0]            out_id_ff;
   logic [11:0]           tw_node_ff, tw_ns_ff;
   logic [5:0]            tw_sym_ff;
   logic                  tw_ok_ff;
   logic [11:0]           tw_q_ff;

   logic [6:0]            in_sym;
   logic                  in_sym_ok;
   logic [POS_W-1:0]      pos;
   logic [TADDR_W-1:0]    rd_taddr, wr_taddr;
   logic [17:0]           tw_rem;
   logic [17:0]           tw_res;
   logic [40:0]           tw_prod;
   logic                  out_free;
   logic                  is_char;

   assign is_char   = (req_kind == 2'(b58m_pkg::KIND_CHAR));
   assign in_sym    = b58m_pkg::sym_of(req_character);
   assign in_sym_ok = !in_sym[6] && (32'(in_sym[5:0]) < ALPHABET_SIZE);
   assign pos       = POS_W'(start_ff) + POS_W'(j_ff);
   assign rd_taddr  = TADDR_W'(32'(node_ff) * ALPHABET_SIZE + 32'(sym_ff));
   assign wr_taddr  = TADDR_W'(32'(tw_node_ff) * ALPHABET_SIZE + 32'(tw_sym_ff));
   assign tw_prod   = 41'(tw_ns_ff) * 41'(RECIP);
   assign tw_rem    = 18'(tw_ns_ff) - 18'(32'(tw_q_ff) * MAX_NODES);
   assign tw_res    = (32'(tw_rem) >= MAX_NODES) ? 18'(32'(tw_rem) - MAX_NODES) : tw_rem;
   assign out_free  = !out_v_ff || rsp_ready;

   always_comb begin
      status            = '0;
      status.in_first   = req_first_char;
      status.in_sym_ok  = in_sym_ok;
      status.epoch_wrap = &epoch_ff;
      status.clr_done   = (32'(clr_ff) == MAX_WORDS - 1);
      status.list_done  = (j_ff == len_ff);
      status.pos_oob    = (32'(pos) >= ID_LIST_DEPTH);
      status.id_ok      = ({1'b0, id_q_ff} < num_words) && (32'(id_q_ff) < MAX_WORDS);
      status.seen_hit   = (seen_q_ff == epoch_ff);
      status.pend_v     = pend_v_ff;
      status.out_free   = out_free;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff   <= '0;
         epoch_ff  <= b58m_pkg::EPOCH_W'(1);
         clr_ff    <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         j_ff      <= '0;
         len_ff    <= '0;
      end else begin
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + (WORD_W + 1)'(1);
         end
         if (cmd.accept && is_char) begin
            if (req_first_char) begin
               node_ff <= '0;
               if (&epoch_ff) begin
                  epoch_ff <= b58m_pkg::EPOCH_W'(1);
                  clr_ff   <= '0;
               end else begin
                  epoch_ff <= epoch_ff + b58m_pkg::EPOCH_W'(1);
               end
            end else if (!in_sym_ok) begin
               node_ff <= '0;
            end
         end
         if (cmd.node_upd) begin
            node_ff <= NODE_W'(trans_q_ff);
         end
         if (cmd.list_init) begin
            j_ff   <= '0;
            len_ff <= (32'(rlen_q_ff) > MAX_OUT_PER_NODE) ? LEN_W'(MAX_OUT_PER_NODE)
                                                           : LEN_W'(rlen_q_ff);
         end
         if (cmd.j_inc || cmd.match) begin
            j_ff <= j_ff + LEN_W'(1);
         end
         if (cmd.flush || (cmd.match && pend_v_ff)) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
         if (cmd.match) begin
            pend_v_ff <= 1'b1;
         end
         if (cmd.flush) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff     <= in_sym[5:0];
         tw_node_ff <= req_table_state;
         tw_sym_ff  <= req_symbol;
         tw_ns_ff   <= req_next_state;
         tw_ok_ff   <= (32'(req_table_state) < MAX_NODES) && (32'(req_symbol) < ALPHABET_SIZE);
      end
      if (cmd.tw_mul) begin
         tw_q_ff <= 12'(tw_prod >> SHIFT);
      end
      if (cmd.list_init) begin
         start_ff <= rstart_q_ff;
      end
      if (cmd.match) begin
         pend_id_ff <= id_q_ff;
         if (pend_v_ff) begin
            out_id_ff   <= pend_id_ff;
            out_last_ff <= 1'b0;
         end
      end
      if (cmd.flush) begin
         out_id_ff   <= pend_id_ff;
         out_last_ff <= 1'b1;
      end
   end

   // Transition table.
   always_ff @(posedge clock) begin
      if (cmd.tw_wr && tw_ok_ff) begin
         trans_mem[wr_taddr] <= 12'(tw_res);
      end
      if (cmd.trans_rd) begin
         trans_q_ff <= trans_mem[rd_taddr];
      end
   end

   // Output range tables.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_kind == 2'(b58m_pkg::KIND_RANGE)
          && 32'(req_table_state) < MAX_NODES) begin
         rstart_mem[NODE_W'(req_table_state)] <= req_out_start;
         rlen_mem[NODE_W'(req_table_state)]   <= req_out_len;
      end
      if (cmd.node_upd) begin
         rstart_q_ff <= rstart_mem[NODE_W'(trans_q_ff)];
         rlen_q_ff   <= rlen_mem[NODE_W'(trans_q_ff)];
      end
   end

   // Word id list.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_kind == 2'(b58m_pkg::KIND_ID)
          && 32'(req_out_index) < ID_LIST_DEPTH) begin
         id_mem[IDX_W'(req_out_index)] <= req_word_id;
      end
      if (cmd.id_rd) begin
         id_q_ff <= id_mem[IDX_W'(pos)];
      end
   end

   // Seen store: an entry is seen when it holds the current address epoch.
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         seen_mem[WORD_W'(clr_ff)] <= '0;
      end else if (cmd.match) begin
         seen_mem[WORD_W'(id_q_ff)] <= epoch_ff;
      end
      if (cmd.seen_rd) begin
         seen_q_ff <= seen_mem[WORD_W'(id_q_ff)];
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_match_id = out_id_ff;
   assign rsp_last     = out_last_ff;

endmodule

// File: rtl/base58_multi_pattern_matcher_core.sv
// Top level of the Base58 Aho-Corasick multi-pattern matcher.
//
//   Channel  Direction  Transfer carries
//   req_     in         one address character or one table write
//   rsp_     out        one newly found word id, with last on the final one of a character
//   csr_     in         the number of dictionary words
//
// A table write or a skipped character is taken in the idle state; a transition write
// passes through a multiply state and a write state. A matched character passes through the
// table read, range read, list set-up, the end of list check and the last result, plus the
// list check, an id list read and a seen store read for each output list entry.
// After reset, and after every 255th address start, the seen store is cleared one entry a
// cycle, during which no character is taken.
// A stalled result register holds the walk at the next new match or at the end of the list.
module base58_multi_pattern_matcher_core #(
   parameter int ALPHABET_SIZE    = 58,
   parameter int MAX_NODES        = 4096,
   parameter int MAX_WORDS        = 1024,
   parameter int ID_LIST_DEPTH    = 8192,
   parameter int MAX_OUT_PER_NODE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_first_char,
   input  logic [7:0]  req_character,
   input  logic [11:0] req_table_state,
   input  logic [5:0]  req_symbol,
   input  logic [11:0] req_next_state,
   input  logic [12:0] req_out_start,
   input  logic [4:0]  req_out_len,
   input  logic [12:0] req_out_index,
   input  logic [9:0]  req_word_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_match_id,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_num_words
);

   b58m_pkg::cmd_type    cmd;
   b58m_pkg::status_type status;
   logic [10:0]          num_words_ff;

   // The word count register takes a transfer in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_words_ff <= '0;
      end else if (csr_valid) begin
         num_words_ff <= csr_num_words;
      end
   end

   b58m_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   b58m_dp #(
      .ALPHABET_SIZE    (ALPHABET_SIZE),
      .MAX_NODES        (MAX_NODES),
      .MAX_WORDS        (MAX_WORDS),
      .ID_LIST_DEPTH    (ID_LIST_DEPTH),
      .MAX_OUT_PER_NODE (MAX_OUT_PER_NODE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .num_words       (num_words_ff),
      .req_kind        (req_kind),
      .req_first_char  (req_first_char),
      .req_character   (req_character),
      .req_table_state (req_table_state),
      .req_symbol      (req_symbol),
      .req_next_state  (req_next_state),
      .req_out_start   (req_out_start),
      .req_out_len     (req_out_len),
      .req_out_index   (req_out_index),
      .req_word_id     (req_word_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_id    (rsp_match_id),
      .rsp_last        (rsp_last)
   );

endmodule
